// ===== src/bmie_pkg.sv =====
// Shared types and constants for the byte machine instruction execute block.
package bmie_pkg;

    localparam int DATA_W    = 8;
    localparam int MEM_DEPTH = 256;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    // Fixed destination of the device read command.
    localparam logic [ADDR_W-1:0] READ_TARGET = ADDR_W'(MEM_DEPTH - 1);

    typedef enum logic [7:0] {
        CMD_STORE_IMM     = 8'd1,
        CMD_COPY          = 8'd2,
        CMD_STORE_IMM_EQZ = 8'd3,
        CMD_COPY_EQZ      = 8'd4,
        CMD_STORE_IMM_GTZ = 8'd5,
        CMD_COPY_GTZ      = 8'd6,
        CMD_ADD           = 8'd7,
        CMD_SUB           = 8'd8,
        CMD_DEV_READ      = 8'd9,
        CMD_DEV_WRITE     = 8'd10
    } t_cmd;

    // Signed byte strictly greater than zero.
    function automatic logic f_pos(input logic [DATA_W-1:0] b);
        return (b != '0) && !b[DATA_W-1];
    endfunction

endpackage

// ===== src/bmie_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module bmie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/byte_machine_instruction_execute.sv =====
// Top level: one-instruction-per-transfer byte machine over a 256-byte data memory.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_command, i_*_address, i_immediate_value,
//          |           |                           | i_io_read_data
//  out     | output    | o_out_valid / i_out_ready | o_io_write_valid, o_io_write_data,
//          |           |                           | o_memory_written, o_bad_command
//
//  One instruction per cycle if not stalled; results pass execute stage and result register.
//  The three operand reads go to three copies of the memory, issued at the input transfer;
//  the write of the instruction ahead is forwarded when it lands in that same cycle.
//  After reset a clearing pass writes zero to all 256 bytes, one per cycle, and holds the
//  input off until it ends.
//  A stalled output holds the execute stage; the input stalls when that stage is full and held.
module byte_machine_instruction_execute
    import bmie_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_command,
    input  logic [ADDR_W-1:0] i_first_address,
    input  logic [ADDR_W-1:0] i_second_address,
    input  logic [ADDR_W-1:0] i_third_address,
    input  logic [DATA_W-1:0] i_immediate_value,
    input  logic [DATA_W-1:0] i_io_read_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_io_write_valid,
    output logic [DATA_W-1:0] o_io_write_data,
    output logic              o_memory_written,
    output logic              o_bad_command
);

    // execute stage
    logic              r_s1_valid;
    logic [7:0]        r_cmd;
    logic [ADDR_W-1:0] r_a1, r_a2, r_a3;
    logic [DATA_W-1:0] r_imm, r_rd;

    // write that landed in the cycle of the input transfer
    logic              r_fwd_en;
    logic [ADDR_W-1:0] r_fwd_addr;
    logic [DATA_W-1:0] r_fwd_data;

    // memory clear after reset
    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;

    // result register
    logic              r_out_valid;
    logic              r_out_io_valid;
    logic [DATA_W-1:0] r_out_io_data;
    logic              r_out_mem_written;
    logic              r_out_bad;

    logic              in_xfer;
    logic              s1_adv;
    logic [DATA_W-1:0] q1, q2, q3;
    logic [DATA_W-1:0] m1, m2, m3;
    logic              do_write;
    logic [ADDR_W-1:0] w_addr;
    logic [DATA_W-1:0] w_data;
    logic              io_valid;
    logic              bad;
    logic              wr_en;
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [DATA_W-1:0] ram_wr_data;

    assign s1_adv     = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_clearing && (!r_s1_valid || s1_adv);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign wr_en      = r_s1_valid && s1_adv && do_write;

    // The clearing pass owns the write port until it ends.
    assign ram_wr_en   = r_clearing || wr_en;
    assign ram_wr_addr = r_clearing ? r_clr_addr : w_addr;
    assign ram_wr_data = r_clearing ? '0 : w_data;

    bmie_ram #(.WIDTH(DATA_W), .DEPTH(MEM_DEPTH)) u_ram1 (
        .i_clk    (i_clk),
        .i_wr_en  (ram_wr_en),
        .i_wr_addr(ram_wr_addr),
        .i_wr_data(ram_wr_data),
        .i_rd_en  (in_xfer),
        .i_rd_addr(i_first_address),
        .o_rd_data(q1)
    );

    bmie_ram #(.WIDTH(DATA_W), .DEPTH(MEM_DEPTH)) u_ram2 (
        .i_clk    (i_clk),
        .i_wr_en  (ram_wr_en),
        .i_wr_addr(ram_wr_addr),
        .i_wr_data(ram_wr_data),
        .i_rd_en  (in_xfer),
        .i_rd_addr(i_second_address),
        .o_rd_data(q2)
    );

    bmie_ram #(.WIDTH(DATA_W), .DEPTH(MEM_DEPTH)) u_ram3 (
        .i_clk    (i_clk),
        .i_wr_en  (ram_wr_en),
        .i_wr_addr(ram_wr_addr),
        .i_wr_data(ram_wr_data),
        .i_rd_en  (in_xfer),
        .i_rd_addr(i_third_address),
        .o_rd_data(q3)
    );

    // Operand select: forwarded write first, else the RAM read data.
    always_comb begin
        m1 = q1;
        m2 = q2;
        m3 = q3;
        if (r_fwd_en && (r_fwd_addr == r_a1)) begin
            m1 = r_fwd_data;
        end
        if (r_fwd_en && (r_fwd_addr == r_a2)) begin
            m2 = r_fwd_data;
        end
        if (r_fwd_en && (r_fwd_addr == r_a3)) begin
            m3 = r_fwd_data;
        end
    end

    always_comb begin
        do_write = 1'b0;
        w_addr   = r_a1;
        w_data   = '0;
        io_valid = 1'b0;
        bad      = 1'b0;
        unique case (t_cmd'(r_cmd))
            CMD_STORE_IMM: begin
                do_write = 1'b1;
                w_data   = r_imm;
            end
            CMD_COPY: begin
                do_write = 1'b1;
                w_data   = m2;
            end
            CMD_STORE_IMM_EQZ: begin
                do_write = (m2 == '0);
                w_data   = r_imm;
            end
            CMD_COPY_EQZ: begin
                do_write = (m3 == '0);
                w_data   = m2;
            end
            CMD_STORE_IMM_GTZ: begin
                do_write = f_pos(m2);
                w_data   = r_imm;
            end
            CMD_COPY_GTZ: begin
                do_write = f_pos(m3);
                w_data   = m2;
            end
            CMD_ADD: begin
                do_write = 1'b1;
                w_data   = m1 + m2;
            end
            CMD_SUB: begin
                do_write = 1'b1;
                w_data   = m1 - m2;
            end
            CMD_DEV_READ: begin
                do_write = 1'b1;
                w_addr   = READ_TARGET;
                w_data   = r_rd;
            end
            CMD_DEV_WRITE: begin
                io_valid = 1'b1;
            end
            default: begin
                bad = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_en   <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_s1_valid <= 1'b1;
                r_fwd_en   <= wr_en;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd      <= i_command;
            r_a1       <= i_first_address;
            r_a2       <= i_second_address;
            r_a3       <= i_third_address;
            r_imm      <= i_immediate_value;
            r_rd       <= i_io_read_data;
            r_fwd_addr <= w_addr;
            r_fwd_data <= w_data;
        end
    end

    // Walk every address once after reset, writing zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ADDR_W'(MEM_DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s1_adv) begin
            r_out_io_valid    <= io_valid;
            r_out_io_data     <= io_valid ? r_imm : '0;
            r_out_mem_written <= do_write;
            r_out_bad         <= bad;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_io_write_valid = r_out_io_valid;
    assign o_io_write_data  = r_out_io_data;
    assign o_memory_written = r_out_mem_written;
    assign o_bad_command    = r_out_bad;

`ifndef SYNTHESIS
    a_one_effect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot0({r_out_io_valid, r_out_mem_written, r_out_bad}))
        else $error("result carries more than one effect");

    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !o_in_ready)
        else $error("input taken while memory is being cleared");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |-> !o_in_ready)
        else $error("input taken while execute stage is stalled");

    a_write_on_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> (r_out_valid && r_out_mem_written))
        else $error("memory write without a matching result");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the byte machine instruction execute block.
module tb;
    import bmie_pkg::*;

    // Command codes outside the defined set
    localparam logic [7:0] BAD_CODE_ZERO  = 8'd0;
    localparam logic [7:0] BAD_CODE_FIRST = 8'd11;
    localparam logic [7:0] BAD_CODE_TOP   = 8'hFF;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 12;
    localparam int IDLE_PCT     = 14;
    localparam int HOLD_CYCLES  = 60;
    localparam int SETTLE_CYCLES = 10;

    typedef struct packed {
        logic [7:0]        cmd;
        logic [ADDR_W-1:0] dst;
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] cond;
        logic [DATA_W-1:0] imm;
        logic [DATA_W-1:0] dev_byte;
    } t_instr;

    typedef struct packed {
        logic              dev_valid;
        logic [DATA_W-1:0] dev_data;
        logic              mem_wr;
        logic              bad;
    } t_outcome;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [7:0]        i_command;
    logic [ADDR_W-1:0] i_first_address;
    logic [ADDR_W-1:0] i_second_address;
    logic [ADDR_W-1:0] i_third_address;
    logic [DATA_W-1:0] i_immediate_value;
    logic [DATA_W-1:0] i_io_read_data;
    logic              o_out_valid;
    logic              i_out_ready;
    logic              o_io_write_valid;
    logic [DATA_W-1:0] o_io_write_data;
    logic              o_memory_written;
    logic              o_bad_command;

    logic [DATA_W-1:0] mem_image [MEM_DEPTH];
    t_outcome          pending_outcomes [$];

    bit send_idle_en = 1'b1;
    bit recv_idle_en = 1'b1;
    bit hold_req     = 1'b0;
    int fail_count   = 0;
    int n_sent       = 0;
    int n_mem_wr     = 0;
    int n_bad        = 0;
    int n_dev_out    = 0;
    int n_checked    = 0;

    byte_machine_instruction_execute dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_command         (i_command),
        .i_first_address   (i_first_address),
        .i_second_address  (i_second_address),
        .i_third_address   (i_third_address),
        .i_immediate_value (i_immediate_value),
        .i_io_read_data    (i_io_read_data),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_io_write_valid  (o_io_write_valid),
        .o_io_write_data   (o_io_write_data),
        .o_memory_written  (o_memory_written),
        .o_bad_command     (o_bad_command)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(CLK_PERIOD * 200000);
        $display("** byte_machine_instruction_execute: FAILED **");
        $finish;
    end

    // Execute one instruction on the memory image; reads see the memory before the write.
    function automatic t_outcome execute_instr(input t_instr ins);
        t_outcome          res;
        logic [DATA_W-1:0] m_dst;
        logic [DATA_W-1:0] m_src;
        logic [DATA_W-1:0] m_cond;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] waddr;
        logic              wr;
        m_dst  = mem_image[ins.dst];
        m_src  = mem_image[ins.src];
        m_cond = mem_image[ins.cond];
        res    = '0;
        wr     = 1'b0;
        waddr  = ins.dst;
        wdata  = '0;
        case (ins.cmd)
            CMD_STORE_IMM: begin
                wr = 1'b1;
                wdata = ins.imm;
            end
            CMD_COPY: begin
                wr = 1'b1;
                wdata = m_src;
            end
            CMD_STORE_IMM_EQZ: begin
                wr = (m_src == '0);
                wdata = ins.imm;
            end
            CMD_COPY_EQZ: begin
                wr = (m_cond == '0);
                wdata = m_src;
            end
            CMD_STORE_IMM_GTZ: begin
                wr = ($signed(m_src) > 0);
                wdata = ins.imm;
            end
            CMD_COPY_GTZ: begin
                wr = ($signed(m_cond) > 0);
                wdata = m_src;
            end
            CMD_ADD: begin
                wr = 1'b1;
                wdata = m_dst + m_src;
            end
            CMD_SUB: begin
                wr = 1'b1;
                wdata = m_dst - m_src;
            end
            CMD_DEV_READ: begin
                wr = 1'b1;
                waddr = READ_TARGET;
                wdata = ins.dev_byte;
            end
            CMD_DEV_WRITE: begin
                res.dev_valid = 1'b1;
                res.dev_data = ins.imm;
            end
            default: begin
                res.bad = 1'b1;
            end
        endcase
        if (wr) mem_image[waddr] = wdata;
        res.mem_wr = wr;
        return res;
    endfunction

    // Offer one instruction, optionally after random idle cycles, and hold it until transfer.
    task automatic send_instr(input t_instr ins);
        t_outcome res;
        @(negedge i_clk);
        while (send_idle_en && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_command         <= ins.cmd;
        i_first_address   <= ins.dst;
        i_second_address  <= ins.src;
        i_third_address   <= ins.cond;
        i_immediate_value <= ins.imm;
        i_io_read_data    <= ins.dev_byte;
        do @(posedge i_clk); while (!o_in_ready);
        res = execute_instr(ins);
        pending_outcomes.push_back(res);
        n_sent++;
        n_mem_wr  += res.mem_wr;
        n_bad     += res.bad;
        n_dev_out += res.dev_valid;
    endtask

    task automatic stop_offering();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_all_results();
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_instr make_instr(input logic [7:0] cmd, input int dst, input int src,
                                          input int cond, input int imm, input int dev_byte);
        t_instr ins;
        ins.cmd      = cmd;
        ins.dst      = ADDR_W'(dst);
        ins.src      = ADDR_W'(src);
        ins.cond     = ADDR_W'(cond);
        ins.imm      = DATA_W'(imm);
        ins.dev_byte = DATA_W'(dev_byte);
        return ins;
    endfunction

    // Mostly hit a small set of addresses so writes feed later reads; sometimes anywhere.
    function automatic logic [ADDR_W-1:0] pick_addr(input int pool);
        int r;
        r = $urandom_range(99);
        if (r < 8) return READ_TARGET;
        if (r < 72) return ADDR_W'($urandom_range(pool - 1));
        return ADDR_W'($urandom_range(MEM_DEPTH - 1));
    endfunction

    function automatic t_instr rand_instr(input int pool);
        t_instr ins;
        int     r;
        r = $urandom_range(99);
        if (r < 82) begin
            ins.cmd = 8'($urandom_range(CMD_DEV_WRITE, CMD_STORE_IMM));
        end else if (r < 86) begin
            ins.cmd = BAD_CODE_ZERO;
        end else begin
            ins.cmd = 8'($urandom_range(255));
        end
        ins.dst  = pick_addr(pool);
        ins.src  = pick_addr(pool);
        ins.cond = pick_addr(pool);
        // Bias immediates toward condition edges: zero, sign boundary and full range
        r = $urandom_range(9);
        case (r)
            0: ins.imm = 8'h00;
            1: ins.imm = 8'h80;
            2: ins.imm = 8'h7F;
            default: ins.imm = 8'($urandom_range(255));
        endcase
        ins.dev_byte = 8'($urandom_range(255));
        return ins;
    endfunction

    task automatic test_directed();
        send_instr(make_instr(CMD_STORE_IMM,     0,   0,   0,   8'h7F, 0));
        send_instr(make_instr(CMD_STORE_IMM,     255, 0,   0,   8'h80, 8'hFF));
        send_instr(make_instr(CMD_STORE_IMM,     1,   255, 255, 8'hFF, 0));
        send_instr(make_instr(CMD_COPY,          2,   0,   0,   0,     0));
        // zero-condition forms, taken and not taken
        send_instr(make_instr(CMD_STORE_IMM_EQZ, 3,   10,  0,   8'hAA, 0));
        send_instr(make_instr(CMD_STORE_IMM_EQZ, 4,   0,   0,   8'h55, 0));
        send_instr(make_instr(CMD_COPY_EQZ,      5,   1,   10,  0,     0));
        send_instr(make_instr(CMD_COPY_EQZ,      6,   1,   0,   0,     0));
        // signed positive forms: 0x7F passes, 0x80, 0xFF and zero fail
        send_instr(make_instr(CMD_STORE_IMM_GTZ, 7,   0,   0,   8'h55, 0));
        send_instr(make_instr(CMD_STORE_IMM_GTZ, 8,   255, 0,   8'h33, 0));
        send_instr(make_instr(CMD_STORE_IMM_GTZ, 8,   1,   0,   8'h33, 0));
        send_instr(make_instr(CMD_STORE_IMM_GTZ, 8,   10,  0,   8'h33, 0));
        send_instr(make_instr(CMD_COPY_GTZ,      9,   255, 0,   0,     0));
        send_instr(make_instr(CMD_COPY_GTZ,      9,   0,   255, 0,     0));
        // same address twice: add doubles, sub clears; wrap both ways
        send_instr(make_instr(CMD_ADD,           0,   0,   0,   0,     0));
        send_instr(make_instr(CMD_ADD,           1,   255, 0,   0,     0));
        send_instr(make_instr(CMD_SUB,           2,   2,   0,   0,     0));
        send_instr(make_instr(CMD_SUB,           10,  1,   0,   0,     0));
        send_instr(make_instr(CMD_DEV_READ,      0,   0,   0,   0,     8'hFF));
        send_instr(make_instr(CMD_DEV_READ,      255, 255, 255, 8'hFF, 8'h00));
        // rewrite of an equal value still counts as a memory write
        send_instr(make_instr(CMD_DEV_READ,      0,   0,   0,   0,     8'h00));
        send_instr(make_instr(CMD_DEV_WRITE,     255, 255, 255, 8'hFF, 8'hFF));
        send_instr(make_instr(CMD_DEV_WRITE,     0,   0,   0,   8'h00, 0));
        send_instr(make_instr(BAD_CODE_ZERO,     255, 255, 255, 8'hFF, 8'hFF));
        send_instr(make_instr(BAD_CODE_FIRST,    3,   3,   3,   8'h12, 8'h34));
        send_instr(make_instr(BAD_CODE_TOP,      0,   0,   0,   0,     0));
    endtask

    task automatic test_random_mix(input int count);
        repeat (count) send_instr(rand_instr(16));
    endtask

    // Back-to-back on a tiny address set to stress forwarding between neighbors.
    task automatic test_back_to_back(input int count);
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        repeat (count) send_instr(rand_instr(4));
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
    endtask

    // Receiver holds off while items keep coming, so the block fills and stalls its input.
    task automatic test_output_stall(input int count);
        send_idle_en = 1'b0;
        hold_req = 1'b1;
        repeat (count) send_instr(rand_instr(8));
        send_idle_en = 1'b1;
    endtask

    // Pause the sender until every outstanding result has come, then resume.
    task automatic test_drain_pause(input int count);
        repeat (count) send_instr(rand_instr(16));
        stop_offering();
        wait_all_results();
        repeat (count) send_instr(rand_instr(16));
    endtask

    // Receiver side: random stalls, plus a long hold when requested.
    initial begin
        int hold_left;
        hold_left = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= !(recv_idle_en && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Compare every result transfer with the oldest outstanding prediction.
    initial begin
        t_outcome want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (pending_outcomes.size() == 0) begin
                    $error("result transfer with no outstanding instruction");
                    fail_count++;
                end else begin
                    want = pending_outcomes.pop_front();
                    n_checked++;
                    if (o_io_write_valid !== want.dev_valid) begin
                        $error("io_write_valid: expected %0d, actual %0d",
                               want.dev_valid, o_io_write_valid);
                        fail_count++;
                    end
                    if (o_io_write_data !== want.dev_data) begin
                        $error("io_write_data: expected 0x%02h, actual 0x%02h",
                               want.dev_data, o_io_write_data);
                        fail_count++;
                    end
                    if (o_memory_written !== want.mem_wr) begin
                        $error("memory_written: expected %0d, actual %0d",
                               want.mem_wr, o_memory_written);
                        fail_count++;
                    end
                    if (o_bad_command !== want.bad) begin
                        $error("bad_command: expected %0d, actual %0d",
                               want.bad, o_bad_command);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_command         = '0;
        i_first_address   = '0;
        i_second_address  = '0;
        i_third_address   = '0;
        i_immediate_value = '0;
        i_io_read_data    = '0;
        for (int k = 0; k < MEM_DEPTH; k++) mem_image[k] = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_mix(300);
        test_back_to_back(150);
        test_output_stall(80);
        test_drain_pause(50);

        stop_offering();
        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_outcomes.size() != 0) begin
            $error("%0d results never arrived", pending_outcomes.size());
            fail_count++;
        end

        $display("Run: %0d instructions sent, %0d results checked, %0d mismatches.",
                 n_sent, n_checked, fail_count);
        $display("Mix: %0d memory writes, %0d device outputs, %0d unknown commands.",
                 n_mem_wr, n_dev_out, n_bad);
        if (fail_count == 0) begin
            $display("** byte_machine_instruction_execute: PASSED **");
        end else begin
            $display("** byte_machine_instruction_execute: FAILED **");
        end
        $finish;
    end

endmodule
